@@ hw/rtl/apt_pkg.sv @@
`default_nettype none

package apt_pkg;

	localparam int unsigned COORD_WIDTH   = 32;
	localparam int unsigned FRAC_BITS_DEF = 16;
	localparam int unsigned NUM_COEF      = 12;
	localparam int unsigned IDX_W         = 4;
	localparam int unsigned OP_W          = 3;
	// power of two so the pointers wrap on their own
	localparam int unsigned QUEUE_DEPTH   = 4;

	localparam int unsigned IN_DATA_W  = ((IDX_W + 4 * COORD_WIDTH + 7) / 8) * 8;
	localparam int unsigned OUT_DATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8;

	localparam logic [OP_W-1:0] OP_POINT     = 3'd0;
	localparam logic [OP_W-1:0] OP_INV_POINT = 3'd1;
	localparam logic [OP_W-1:0] OP_DIR       = 3'd2;
	localparam logic [OP_W-1:0] OP_INV_DIR   = 3'd3;
	localparam logic [OP_W-1:0] OP_LOAD      = 3'd4;

	typedef enum logic [2:0] {
		KIND_POINT,
		KIND_INV_POINT,
		KIND_DIR,
		KIND_INV_DIR,
		KIND_LOAD
	} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic [IDX_W-1:0]       coef_index;
		logic [COORD_WIDTH-1:0] coef_value;
		logic [COORD_WIDTH-1:0] x;
		logic [COORD_WIDTH-1:0] y;
		logic [COORD_WIDTH-1:0] z;
	} q_entry_t;

	typedef struct packed {
		logic push;
	} q_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/apt_front.sv @@
`default_nettype none

module apt_front (
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// coef_index, coef_value, x_in, y_in, z_in from the lowest bit up, zero padded
	input  wire logic [apt_pkg::IN_DATA_W-1:0] s_tdata,
	// op
	input  wire logic [apt_pkg::OP_W-1:0]      s_tuser,
	input  wire logic                          q_full,
	output apt_pkg::q_ctrl_t                   q_ctrl,
	output apt_pkg::q_entry_t                  q_entry
);
	import apt_pkg::*;

	localparam int unsigned CW = COORD_WIDTH;

	logic  keep;
	kind_t kind;

	always_comb begin
		keep = 1'b1;
		kind = KIND_POINT;
		unique case (s_tuser)
			OP_POINT:     kind = KIND_POINT;
			OP_INV_POINT: kind = KIND_INV_POINT;
			OP_DIR:       kind = KIND_DIR;
			OP_INV_DIR:   kind = KIND_INV_DIR;
			OP_LOAD: begin
				kind = KIND_LOAD;
				// loads past the last coefficient are dropped
				keep = s_tdata[IDX_W-1:0] < IDX_W'(NUM_COEF);
			end
			default:      keep = 1'b0;
		endcase
	end

	assign s_tready = !q_full;

	always_comb begin
		q_entry.kind       = kind;
		q_entry.coef_index = s_tdata[IDX_W-1:0];
		q_entry.coef_value = s_tdata[IDX_W +: CW];
		q_entry.x          = s_tdata[IDX_W + CW +: CW];
		q_entry.y          = s_tdata[IDX_W + 2 * CW +: CW];
		q_entry.z          = s_tdata[IDX_W + 3 * CW +: CW];
		q_ctrl.push        = s_tvalid && !q_full && keep;
	end

endmodule

`default_nettype wire

@@ hw/rtl/apt_queue.sv @@
`default_nettype none

module apt_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire apt_pkg::q_ctrl_t   q_ctrl,
	input  wire apt_pkg::q_entry_t  push_entry,
	output logic                    full,
	input  wire logic               pop,
	output logic                    head_valid,
	output apt_pkg::q_entry_t       head_entry
);
	import apt_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

	q_entry_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_ctrl.push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			unique case ({q_ctrl.push, pop})
				2'b10:   count_q <= count_q + (PTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (PTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_ctrl.push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	assign full       = count_q == (PTR_W + 1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_entry = mem_q[rd_ptr_q];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W + 1)'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_ctrl.push |-> !full)
		else $error("request pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from an empty queue");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(q_ctrl.push && !pop) |=> count_q == $past(count_q) + (PTR_W + 1)'(1))
		else $error("queue count lost a push");

endmodule

`default_nettype wire

@@ hw/rtl/apt_back.sv @@
`default_nettype none

module apt_back #(
	parameter int unsigned FRAC_BITS = apt_pkg::FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           head_valid,
	input  wire apt_pkg::q_entry_t              head_entry,
	output logic                                pop,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// x_out, y_out, z_out from the lowest bit up
	output logic [apt_pkg::OUT_DATA_W-1:0]      m_tdata,
	// saturated
	output logic [0:0]                          m_tuser
);
	import apt_pkg::*;

	localparam int unsigned CW     = COORD_WIDTH;
	localparam int unsigned VEC_W  = CW + 1;
	localparam int unsigned PROD_W = VEC_W + CW;
	localparam int unsigned SUM_W  = PROD_W + 2;
	localparam logic signed [SUM_W-1:0] MAX_S = {{(SUM_W - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
	localparam logic signed [SUM_W-1:0] MIN_S = ~MAX_S;

	logic [CW-1:0] coef_q [NUM_COEF];

	logic adv;
	logic is_load;
	logic row_major;

	logic signed [VEC_W-1:0] vec_d   [3];
	logic signed [CW-1:0]    coef_d  [3][3];
	logic signed [CW-1:0]    trans_d [3];
	logic [CW-1:0]           vec_in  [3];

	logic                    valid_s1;
	logic signed [VEC_W-1:0] vec_s1   [3];
	logic signed [CW-1:0]    coef_s1  [3][3];
	logic signed [CW-1:0]    trans_s1 [3];

	logic                     valid_s2;
	logic signed [PROD_W-1:0] prod_s2  [3][3];
	logic signed [CW-1:0]     trans_s2 [3];

	logic                    valid_s3;
	logic signed [SUM_W-1:0] sum_d  [3];
	logic signed [SUM_W-1:0] sum_s3 [3];

	logic          out_valid_q;
	logic [CW-1:0] res_d [3];
	logic [2:0]    clip_d;
	logic [CW-1:0] res_q [3];
	logic          sat_q;

	assign adv     = !out_valid_q || m_tready;
	assign pop     = adv && head_valid;
	assign is_load = head_entry.kind == KIND_LOAD;
	assign row_major = head_entry.kind == KIND_POINT || head_entry.kind == KIND_DIR;

	assign vec_in[0] = head_entry.x;
	assign vec_in[1] = head_entry.y;
	assign vec_in[2] = head_entry.z;

	// operand selection: transposed 3x3 part for the inverse modes, translation subtracted first for inverse point
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			vec_d[c] = $signed({vec_in[c][CW-1], vec_in[c]});
			if (head_entry.kind == KIND_INV_POINT) begin
				vec_d[c] = vec_d[c] - $signed({coef_q[4 * c + 3][CW-1], coef_q[4 * c + 3]});
			end
		end
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				coef_d[r][c] = row_major ? $signed(coef_q[4 * r + c]) : $signed(coef_q[4 * c + r]);
			end
			trans_d[r] = (head_entry.kind == KIND_POINT) ? $signed(coef_q[4 * r + 3]) : '0;
		end
	end

	// loads are applied in request order, so later points see them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEF; i++) begin
				coef_q[i] <= '0;
			end
		end else if (pop && is_load) begin
			coef_q[head_entry.coef_index] <= head_entry.coef_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= head_valid && !is_load;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				vec_s1[r]   <= vec_d[r];
				trans_s1[r] <= trans_d[r];
				trans_s2[r] <= trans_s1[r];
				sum_s3[r]   <= sum_d[r];
				res_q[r]    <= res_d[r];
				for (int c = 0; c < 3; c++) begin
					coef_s1[r][c] <= coef_d[r][c];
					prod_s2[r][c] <= vec_s1[c] * coef_s1[r][c];
				end
			end
			sat_q <= |clip_d;
		end
	end

	// each product is floored by the fraction shift before the exact sum
	always_comb begin
		logic signed [PROD_W-1:0] sh;
		for (int r = 0; r < 3; r++) begin
			sum_d[r] = $signed({{(SUM_W - CW){trans_s2[r][CW-1]}}, trans_s2[r]});
			for (int c = 0; c < 3; c++) begin
				sh = prod_s2[r][c] >>> FRAC_BITS;
				sum_d[r] = sum_d[r] + $signed({{(SUM_W - PROD_W){sh[PROD_W-1]}}, sh});
			end
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			clip_d[r] = 1'b1;
			priority if (sum_s3[r] > MAX_S) begin
				res_d[r] = MAX_S[CW-1:0];
			end else if (sum_s3[r] < MIN_S) begin
				res_d[r] = MIN_S[CW-1:0];
			end else begin
				res_d[r]  = sum_s3[r][CW-1:0];
				clip_d[r] = 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'({res_q[2], res_q[1], res_q[0]});
	assign m_tuser  = sat_q;

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && is_load) |=> !valid_s1)
		else $error("load request entered the datapath");

	a_xform_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !is_load) |=> valid_s1)
		else $error("transform request lost at issue");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv && valid_s3) |=> (valid_s3 && $stable(sum_s3[0])))
		else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

@@ hw/rtl/affine_point_transform.sv @@
`default_nettype none

// Affine point transform: holds a 3x4 signed Q16.16 matrix (row-major, entry 4r+3 is
// translation r, all zero after reset) and, unless the output is stalled, transforms
// one x, y, z vector per cycle in point, inverse point, direction or inverse direction
// mode, each component saturated to 32 bits with the saturated flag in tuser. A load
// request (op 4) writes one coefficient and gives no result; a load past index eleven
// and op codes five to seven are dropped. Throughput is one request per cycle unless
// the output is stalled; a result passes the request queue issue, multiply, shift and
// sum, and saturate registers in that order. A four-entry request queue sits between
// the input and the datapath, so the input keeps taking requests while the output is
// held until the queue is full; loads take effect in request order.
module affine_point_transform #(
	parameter int unsigned FRAC_BITS = apt_pkg::FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// coef_index, coef_value, x_in, y_in, z_in from the lowest bit up, zero padded
	input  wire logic [apt_pkg::IN_DATA_W-1:0]  s_tdata,
	// op
	input  wire logic [apt_pkg::OP_W-1:0]       s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// x_out, y_out, z_out from the lowest bit up
	output logic [apt_pkg::OUT_DATA_W-1:0]      m_tdata,
	// saturated
	output logic [0:0]                          m_tuser
);
	import apt_pkg::*;

	q_ctrl_t  q_ctrl;
	q_entry_t push_entry;
	q_entry_t head_entry;
	logic     q_full;
	logic     head_valid;
	logic     pop;

	apt_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_ctrl   (q_ctrl),
		.q_entry  (push_entry)
	);

	apt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_ctrl     (q_ctrl),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	apt_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

`default_nettype wire

@@ test/affine_point_transform_test.sv @@
`timescale 1ns / 1ps

module affine_point_transform_test;
	import apt_pkg::*;

	localparam int FRAC           = FRAC_BITS_DEF;
	localparam int RANDOM_ITEMS   = 750;
	localparam int CALM_TAIL      = 100;
	localparam int LONG_HOLD      = 64;
	localparam int STALL_LIMIT    = 1000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int IN_FIELDS_W    = IDX_W + 4 * COORD_WIDTH;

	// op codes the block drops
	localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

	localparam logic [31:0] Q_MAX  = 32'h7fff_ffff;
	localparam logic [31:0] Q_MIN  = 32'h8000_0000;
	localparam logic [31:0] Q_ONE  = 32'h0001_0000;
	localparam logic [31:0] JUNK   = 32'ha5a5_5a5a;

	localparam logic signed [95:0] SUM_MAX = 96'sd2147483647;
	localparam logic signed [95:0] SUM_MIN = -96'sd2147483648;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] idx;
		logic [31:0]      coef;
		logic [31:0]      x;
		logic [31:0]      y;
		logic [31:0]      z;
	} request_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        sat;
	} vec_result_t;

	typedef struct {
		request_t    rq;
		bit          typed;
		vec_result_t want;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [OP_W-1:0]       s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [0:0]            m_tuser;

	logic signed [31:0] matrix_terms [NUM_COEF];
	vec_result_t        pending_vectors [$];
	stim_row_t          stim_rows [$];

	bit calm;
	int mismatches;
	int results_checked;
	int clipped_results;
	int loads_taken;
	int transforms_taken;
	int ignored_taken;
	int idle_cycles;

	affine_point_transform dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic vec_result_t transform_vector(input logic [OP_W-1:0] op,
		input logic signed [31:0] vx, input logic signed [31:0] vy,
		input logic signed [31:0] vz);
		logic signed [95:0] v [3];
		logic signed [95:0] acc;
		logic signed [95:0] term;
		logic [31:0]        comp [3];
		vec_result_t        res;
		v[0] = vx;
		v[1] = vy;
		v[2] = vz;
		res.sat = 1'b0;
		// inverse point removes the translation first, at full width
		if (op == OP_INV_POINT)
			for (int c = 0; c < 3; c++)
				v[c] = v[c] - matrix_terms[4 * c + 3];
		for (int r = 0; r < 3; r++) begin
			acc = '0;
			for (int c = 0; c < 3; c++) begin
				if (op == OP_POINT || op == OP_DIR)
					term = matrix_terms[4 * r + c];
				else
					term = matrix_terms[4 * c + r];
				acc = acc + ((v[c] * term) >>> FRAC);
			end
			if (op == OP_POINT)
				acc = acc + matrix_terms[4 * r + 3];
			if (acc > SUM_MAX) begin
				comp[r] = Q_MAX;
				res.sat = 1'b1;
			end else if (acc < SUM_MIN) begin
				comp[r] = Q_MIN;
				res.sat = 1'b1;
			end else begin
				comp[r] = acc[31:0];
			end
		end
		res.x = comp[0];
		res.y = comp[1];
		res.z = comp[2];
		return res;
	endfunction

	function automatic void add_row(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
		input logic [31:0] coef, input logic [31:0] x, input logic [31:0] y,
		input logic [31:0] z, input bit typed = 1'b0, input logic [31:0] ex = '0,
		input logic [31:0] ey = '0, input logic [31:0] ez = '0, input logic es = 1'b0);
		stim_row_t row;
		row.rq    = '{op, idx, coef, x, y, z};
		row.typed = typed;
		row.want  = '{ex, ey, ez, es};
		stim_rows.push_back(row);
	endfunction

	// mix of full-range, shifted-down and edge values
	function automatic logic [31:0] random_q();
		logic signed [31:0] t;
		t = $urandom;
		case ($urandom_range(0, 5))
			0: return t;
			1: begin
				case ($urandom_range(0, 4))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return Q_ONE;
					3: return '1;
					default: return '0;
				endcase
			end
			default: return t >>> $urandom_range(4, 24);
		endcase
	endfunction

	function automatic request_t random_request();
		request_t rq;
		int pick;
		pick    = $urandom_range(0, 99);
		rq.idx  = $urandom_range(0, 15);
		rq.coef = $urandom;
		rq.x    = random_q();
		rq.y    = random_q();
		rq.z    = random_q();
		if (pick < 18) begin
			rq.op   = OP_LOAD;
			rq.coef = random_q();
			rq.idx  = (pick < 16) ? IDX_W'($urandom_range(0, NUM_COEF - 1))
				: IDX_W'($urandom_range(NUM_COEF, 15));
		end else if (pick < 22) begin
			rq.op = OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
		end else begin
			rq.op = OP_W'($urandom_range(OP_POINT, OP_INV_DIR));
		end
		return rq;
	endfunction

	function automatic bit is_ignored(input request_t rq);
		return rq.op > OP_LOAD || (rq.op == OP_LOAD && rq.idx >= NUM_COEF);
	endfunction

	// present one request, wait for it to be taken, then update the model state
	task automatic offer(input stim_row_t row);
		logic [IN_DATA_W-1:0] word;
		word = '0;
		word[IN_FIELDS_W-1:0] = {row.rq.z, row.rq.y, row.rq.x, row.rq.coef, row.rq.idx};
		s_tvalid <= 1'b1;
		s_tuser  <= row.rq.op;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		if (is_ignored(row.rq)) begin
			ignored_taken++;
		end else if (row.rq.op == OP_LOAD) begin
			matrix_terms[row.rq.idx] = row.rq.coef;
			loads_taken++;
		end else begin
			transforms_taken++;
			if (row.typed)
				pending_vectors.push_back(row.want);
			else
				pending_vectors.push_back(transform_vector(row.rq.op, row.rq.x, row.rq.y,
					row.rq.z));
		end
		if (!calm && $urandom_range(0, 99) < 12) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic check_result();
		vec_result_t want;
		logic [31:0] exp_f [4];
		logic [31:0] got_f [4];
		string       names [4];
		results_checked++;
		if (m_tuser[0])
			clipped_results++;
		if (pending_vectors.size() == 0) begin
			$display("%0t: unexpected result x=%h y=%h z=%h sat=%b", $time,
				m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser[0]);
			mismatches++;
			return;
		end
		want  = pending_vectors.pop_front();
		exp_f = '{want.x, want.y, want.z, {31'b0, want.sat}};
		got_f = '{m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], {31'b0, m_tuser[0]}};
		names = '{"x_out", "y_out", "z_out", "saturated"};
		for (int i = 0; i < 4; i++)
			if (exp_f[i] !== got_f[i]) begin
				$display("%0t: %s mismatch, expected %h, got %h", $time, names[i],
					exp_f[i], got_f[i]);
				mismatches++;
			end
	endtask

	// output side: random stalls, one long hold-off early on, none in the tail
	initial begin
		int  stall_left;
		bit  long_hold_done;
		stall_left     = 0;
		long_hold_done = 1'b0;
		m_tready       = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				check_result();
			if (stall_left > 0)
				stall_left--;
			else if (!long_hold_done && results_checked >= 100) begin
				long_hold_done = 1'b1;
				stall_left     = LONG_HOLD;
			end else if (!calm && $urandom_range(0, 99) < 10)
				stall_left = $urandom_range(1, 10);
			m_tready <= (stall_left == 0);
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
		$display("affine_point_transform regression: fail");
		$finish;
	end

	initial begin
		int counted;
		request_t rq;
		stim_row_t row;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = OP_POINT;
		calm     = 1'b0;
		foreach (matrix_terms[i])
			matrix_terms[i] = '0;

		// matrix is all zero after reset
		add_row(OP_POINT, 4'hf, JUNK, Q_MAX, Q_MIN, 32'h1234_5678, 1'b1);
		add_row(OP_INV_POINT, 4'hf, JUNK, Q_MAX, Q_MIN, 32'h1234_5678, 1'b1);
		add_row(OP_DIR, 4'hf, JUNK, Q_MAX, Q_MIN, 32'h1234_5678, 1'b1);
		add_row(OP_INV_DIR, 4'hf, JUNK, Q_MAX, Q_MIN, 32'h1234_5678, 1'b1);
		add_row(OP_RSVD5, 4'h0, Q_ONE, Q_MAX, Q_MAX, Q_MAX);
		add_row(OP_RSVD6, 4'h3, Q_MAX, Q_ONE, Q_ONE, Q_ONE);
		add_row(OP_RSVD7, 4'hb, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		// loads past the last coefficient must not land anywhere
		add_row(OP_LOAD, 4'hf, Q_MAX, JUNK, JUNK, JUNK);
		add_row(OP_LOAD, IDX_W'(NUM_COEF), Q_MIN, JUNK, JUNK, JUNK);
		add_row(OP_POINT, 4'h0, '0, Q_ONE, Q_ONE, Q_ONE, 1'b1);
		// full-scale products clip both ways
		add_row(OP_LOAD, 4'd0, Q_MAX, '0, '0, '0);
		add_row(OP_POINT, 4'h7, JUNK, Q_MAX, '0, '0, 1'b1, Q_MAX, '0, '0, 1'b1);
		add_row(OP_LOAD, 4'd0, Q_MIN, JUNK, JUNK, JUNK);
		add_row(OP_POINT, 4'h7, JUNK, Q_MAX, '0, '0, 1'b1, Q_MIN, '0, '0, 1'b1);
		add_row(OP_POINT, 4'h7, JUNK, Q_MIN, '0, '0, 1'b1, Q_MAX, '0, '0, 1'b1);
		// translation alone reaches the output unclipped
		add_row(OP_LOAD, 4'd11, Q_MIN, '0, '0, '0);
		add_row(OP_POINT, 4'h2, JUNK, '0, '0, '0, 1'b1, '0, '0, Q_MIN, 1'b0);
		add_row(OP_LOAD, 4'd3, Q_MAX, '0, '0, '0);
		add_row(OP_POINT, 4'h2, JUNK, '0, '0, '0, 1'b1, Q_MAX, '0, Q_MIN, 1'b0);
		// difference wider than 32 bits before the multiply
		add_row(OP_INV_POINT, 4'h9, JUNK, Q_MIN, '0, '0, 1'b1, Q_MAX, '0, '0, 1'b1);
		add_row(OP_LOAD, 4'd5, Q_ONE, '0, '0, '0);
		add_row(OP_DIR, 4'h1, JUNK, 32'h0002_0000, 32'hfffd_0000, 32'h0000_8000);
		add_row(OP_INV_DIR, 4'h1, JUNK, 32'h0002_0000, 32'hfffd_0000, 32'h0000_8000);
		add_row(OP_LOAD, 4'd10, 32'hffff_8000, '0, '0, '0);
		add_row(OP_INV_POINT, 4'he, JUNK, 32'h1234_5678, 32'h8765_4321, Q_MAX);
		add_row(OP_POINT, 4'hc, Q_ONE, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0001);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i])
			offer(stim_rows[i]);

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			rq = random_request();
			if (!is_ignored(rq))
				counted++;
			if (counted >= RANDOM_ITEMS - CALM_TAIL)
				calm = 1'b1;
			row.rq    = rq;
			row.typed = 1'b0;
			row.want  = '{'0, '0, '0, 1'b0};
			offer(row);
		end
		s_tvalid <= 1'b0;

		while (pending_vectors.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("requests taken: %0d loads, %0d transforms, %0d dropped by the block",
			loads_taken, transforms_taken, ignored_taken);
		$display("results compared: %0d (%0d clipped), field mismatches: %0d",
			results_checked, clipped_results, mismatches);
		if (mismatches == 0)
			$display("affine_point_transform regression: pass");
		else
			$display("affine_point_transform regression: fail");
		$finish;
	end

endmodule
